/* hw/rtl/itp_pkg.sv */
// Shared types, opcodes and interval helpers for the prescaled interval timer.
package itp_pkg;

   // Operation codes carried in the request opcode field.
   localparam logic [1:0] OP_TICK        = 2'd0;
   localparam logic [1:0] OP_WRITE       = 2'd1;
   localparam logic [1:0] OP_READ_COUNT  = 2'd2;
   localparam logic [1:0] OP_READ_STATUS = 2'd3;

   // Interval select codes.
   localparam logic [1:0] SEL_1    = 2'd0;
   localparam logic [1:0] SEL_8    = 2'd1;
   localparam logic [1:0] SEL_64   = 2'd2;
   localparam logic [1:0] SEL_1024 = 2'd3;

   // Widths of the timer state.
   localparam int COUNT_W    = 8;
   localparam int PRESCALE_W = 11;

   // Reset values and fixed patterns.
   localparam logic [COUNT_W-1:0]    COUNT_RESET    = 8'hD5;
   localparam logic [COUNT_W-1:0]    COUNT_WRAP     = 8'hFF;
   localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 11'h400;
   localparam logic [PRESCALE_W-1:0] PRESCALE_ONE   = 11'h001;

   // Request transaction payload.
   typedef struct packed {
      logic [1:0]         opcode;
      logic [1:0]         interval_select;
      logic [COUNT_W-1:0] write_data;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic [COUNT_W-1:0] read_data;
      logic               underflow_flag;
   } rsp_type;

   // Timer state as one bundle.
   typedef struct packed {
      logic [COUNT_W-1:0]    count;
      logic [PRESCALE_W-1:0] remaining;
      logic [1:0]            chosen;
      logic                  fast;
      logic                  flag;
   } timer_state_type;

   // Number of ticks per decrement for an interval select code.
   function automatic logic [PRESCALE_W-1:0] interval_len(input logic [1:0] sel);
      logic [PRESCALE_W-1:0] len;
      begin
         unique case (sel)
            SEL_1:    len = 11'h001;
            SEL_8:    len = 11'h008;
            SEL_64:   len = 11'h040;
            SEL_1024: len = 11'h400;
            default:  len = 11'h400;
         endcase
         return len;
      end
   endfunction

   // One prescaler tick applied to a timer state.
   function automatic timer_state_type do_tick(input timer_state_type st);
      timer_state_type nx;
      begin
         nx = st;
         if (st.remaining <= PRESCALE_ONE) begin
            if (st.count == '0) begin
               // Underflow: wrap, raise the flag and drop to one tick per step.
               nx.count     = COUNT_WRAP;
               nx.fast      = 1'b1;
               nx.remaining = PRESCALE_ONE;
               nx.flag      = 1'b1;
            end else begin
               nx.count     = st.count - 8'd1;
               nx.remaining = st.fast ? PRESCALE_ONE : interval_len(st.chosen);
            end
         end else begin
            nx.remaining = st.remaining - PRESCALE_ONE;
         end
         return nx;
      end
   endfunction

endpackage

/* hw/rtl/interval_timer_prescaled_unit.sv */
// Top level of the prescaled interval timer: input register, timer state and response register.
// An 8-bit down-counting interval timer with a prescaler of 1, 8, 64 or 1024 ticks per
// decrement. Each request transaction is a tick, a timer write, a count read or a status
// read, and each yields exactly one response transaction carrying the read byte (zero for
// ticks and writes) and the underflow flag after that request. A request passes through an
// input register, is applied to the timer state by one level of short logic, and lands in a
// response register, from which its response is presented; one request is accepted every
// cycle as long as the response side keeps taking transactions, and the input register
// stalls only while it holds a request and the response register is full and itself stalled.
// After reset the count is 0xD5 at the 1024-tick interval with the flag clear.
module interval_timer_prescaled_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  itp_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output itp_pkg::rsp_type         rsp_data
);

   // Input register.
   logic                      in_valid_ff, in_valid_in;
   itp_pkg::req_type          in_data_ff, in_data_in;

   // Timer state.
   itp_pkg::timer_state_type  state_ff, state_in;

   // Response register.
   logic                      out_valid_ff, out_valid_in;
   itp_pkg::rsp_type          out_data_ff, out_data_in;

   // Handshake control.
   logic                      out_free;
   logic                      advance;
   logic                      req_take;
   itp_pkg::timer_state_type  loaded;
   itp_pkg::timer_state_type  applied;
   logic [itp_pkg::COUNT_W-1:0] read_byte;

   // The response register frees when empty or when its transaction is taken.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Input register next values.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Apply the registered request to the timer state.
   always_comb begin
      loaded    = state_ff;
      applied   = state_ff;
      read_byte = '0;
      unique case (in_data_ff.opcode)
         itp_pkg::OP_TICK: begin
            applied = itp_pkg::do_tick(state_ff);
         end
         itp_pkg::OP_WRITE: begin
            loaded.chosen    = in_data_ff.interval_select;
            loaded.fast      = 1'b0;
            loaded.remaining = itp_pkg::interval_len(in_data_ff.interval_select);
            loaded.count     = in_data_ff.write_data;
            loaded.flag      = 1'b0;
            applied          = itp_pkg::do_tick(loaded);
         end
         itp_pkg::OP_READ_COUNT: begin
            applied.fast = 1'b0;
            read_byte    = state_ff.count;
         end
         itp_pkg::OP_READ_STATUS: begin
            read_byte = {state_ff.flag, 7'b0000000};
         end
         default: begin
            applied = state_ff;
         end
      endcase
   end

   // State and response register next values.
   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         state_in                   = applied;
         out_valid_in               = 1'b1;
         out_data_in.read_data      = read_byte;
         out_data_in.underflow_flag = applied.flag;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         state_ff.count     <= itp_pkg::COUNT_RESET;
         state_ff.remaining <= itp_pkg::PRESCALE_RESET;
         state_ff.chosen    <= itp_pkg::SEL_1024;
         state_ff.fast      <= 1'b0;
         state_ff.flag      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* tb/itp_checker.sv */
// Checker for the prescaled interval timer: predicts each response and compares it.
`timescale 1ns / 1ps

module itp_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  itp_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  itp_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count
);

   // Predicted timer state.
   logic [itp_pkg::COUNT_W-1:0]    count_q;
   logic [itp_pkg::PRESCALE_W-1:0] ticks_left_q;
   logic [1:0]                     chosen_q;
   logic                           fast_q;
   logic                           flag_q;

   itp_pkg::rsp_type expected_rsps[$];
   int               mismatches = 0;

   // Ticks per decrement for an interval select code.
   function automatic logic [itp_pkg::PRESCALE_W-1:0] ticks_per_step(input logic [1:0] sel);
      case (sel)
         itp_pkg::SEL_1:  return 11'd1;
         itp_pkg::SEL_8:  return 11'd8;
         itp_pkg::SEL_64: return 11'd64;
         default:         return 11'd1024;
      endcase
   endfunction

   // One prescaler tick on the predicted state.
   function automatic void step_prescaler();
      if (ticks_left_q <= 11'd1) begin
         ticks_left_q = fast_q ? 11'd1 : ticks_per_step(chosen_q);
         if (count_q == 8'd0) begin
            // The count wraps, the flag rises and counting drops to one tick per step.
            count_q      = 8'hFF;
            fast_q       = 1'b1;
            ticks_left_q = 11'd1;
            flag_q       = 1'b1;
         end else begin
            count_q = count_q - 8'd1;
         end
      end else begin
         ticks_left_q = ticks_left_q - 11'd1;
      end
   endfunction

   // Applies one request transaction to the predicted state and returns its response.
   function automatic itp_pkg::rsp_type apply_timer_request(input itp_pkg::req_type req);
      itp_pkg::rsp_type rsp;
      rsp.read_data = '0;
      case (req.opcode)
         itp_pkg::OP_TICK: begin
            step_prescaler();
         end
         itp_pkg::OP_WRITE: begin
            chosen_q     = req.interval_select;
            fast_q       = 1'b0;
            ticks_left_q = ticks_per_step(req.interval_select);
            count_q      = req.write_data;
            flag_q       = 1'b0;
            step_prescaler();
         end
         itp_pkg::OP_READ_COUNT: begin
            fast_q        = 1'b0;
            rsp.read_data = count_q;
         end
         default: begin
            rsp.read_data = {flag_q, 7'b0};
         end
      endcase
      rsp.underflow_flag = flag_q;
      return rsp;
   endfunction

   // Watch both channels; responses are checked before the new request is predicted.
   always @(posedge clock) begin : watch
      itp_pkg::rsp_type want;
      if (reset) begin
         count_q      = itp_pkg::COUNT_RESET;
         ticks_left_q = itp_pkg::PRESCALE_RESET;
         chosen_q     = itp_pkg::SEL_1024;
         fast_q       = 1'b0;
         flag_q       = 1'b0;
         expected_rsps.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response transaction: read_data %0h underflow_flag %0b",
                      rsp_data.read_data, rsp_data.underflow_flag);
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.read_data !== want.read_data) begin
                  $error("read_data: expected %0h, actual %0h",
                         want.read_data, rsp_data.read_data);
                  mismatches++;
               end
               if (rsp_data.underflow_flag !== want.underflow_flag) begin
                  $error("underflow_flag: expected %0b, actual %0b",
                         want.underflow_flag, rsp_data.underflow_flag);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_rsps.push_back(apply_timer_request(req_data));
      end
      error_count   <= mismatches;
      pending_count <= expected_rsps.size();
   end

endmodule

/* tb/tb.sv */
// Testbench top for the prescaled interval timer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_ITEMS = 340;
   localparam int CYCLE_LIMIT  = 400000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   itp_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   itp_pkg::rsp_type rsp_data;

   int error_count;
   int pending_count;
   int cycle_count        = 0;
   int sender_idle_pct    = 14;
   int receiver_stall_pct = 86;
   int random_sent        = 0;

   interval_timer_prescaled_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   itp_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   // The response side stalls at random.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Presents one request transaction and returns once it has been accepted.
   task automatic send_request(input logic [1:0] op, input logic [1:0] sel,
                               input logic [7:0] data);
      itp_pkg::req_type next_req;
      next_req.opcode          = op;
      next_req.interval_select = sel;
      next_req.write_data      = data;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= next_req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_ticks(input int n);
      for (int i = 0; i < n; i++)
         send_request(itp_pkg::OP_TICK, 2'($urandom_range(3)), 8'($urandom));
   endtask

   // Random transaction with every field free.
   task automatic send_noise();
      send_request(2'($urandom_range(3)), 2'($urandom_range(3)), 8'($urandom_range(255)));
      random_sent++;
   endtask

   // A timer write with mostly small counts, followed by ticks and reads.
   task automatic send_timer_sequence();
      logic [1:0] sel;
      logic [7:0] data;
      int         len;
      int         pick;
      sel  = 2'($urandom_range(3));
      data = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
      len  = $urandom_range(1, 24);
      send_request(itp_pkg::OP_WRITE, sel, data);
      random_sent++;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 75)
            send_request(itp_pkg::OP_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)));
         else if (pick < 88)
            send_request(itp_pkg::OP_READ_COUNT, 2'($urandom_range(3)),
                         8'($urandom_range(255)));
         else
            send_request(itp_pkg::OP_READ_STATUS, 2'($urandom_range(3)),
                         8'($urandom_range(255)));
         random_sent++;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset values, then a zero write at interval 1, which underflows at once.
      send_request(itp_pkg::OP_READ_COUNT, itp_pkg::SEL_1, 8'h00);
      send_request(itp_pkg::OP_READ_STATUS, itp_pkg::SEL_1, 8'h00);
      send_request(itp_pkg::OP_TICK, itp_pkg::SEL_1, 8'h00);
      send_request(itp_pkg::OP_WRITE, itp_pkg::SEL_1, 8'h00);
      send_request(itp_pkg::OP_READ_STATUS, itp_pkg::SEL_1, 8'h00);
      send_request(itp_pkg::OP_TICK, itp_pkg::SEL_1, 8'hFF);
      send_request(itp_pkg::OP_READ_COUNT, itp_pkg::SEL_1, 8'h00);
      // Full count at interval 8, stepped through one whole interval.
      send_request(itp_pkg::OP_WRITE, itp_pkg::SEL_8, 8'hFF);
      send_ticks(7);
      send_request(itp_pkg::OP_READ_COUNT, itp_pkg::SEL_8, 8'h00);
      // Other intervals, and a count of two at interval 1 run into underflow.
      send_request(itp_pkg::OP_WRITE, itp_pkg::SEL_64, 8'h01);
      send_request(itp_pkg::OP_WRITE, itp_pkg::SEL_1024, 8'h00);
      send_request(itp_pkg::OP_READ_STATUS, itp_pkg::SEL_1024, 8'hFF);
      send_request(itp_pkg::OP_WRITE, itp_pkg::SEL_1, 8'h02);
      send_ticks(2);
      send_request(itp_pkg::OP_READ_COUNT, itp_pkg::SEL_1, 8'h00);
      send_request(itp_pkg::OP_READ_STATUS, itp_pkg::SEL_1, 8'h00);
      send_request(itp_pkg::OP_WRITE, itp_pkg::SEL_64, 8'hAA);

      // Random part: idling switches from the sender-light to the receiver-light mix, then stops.
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end else if (random_sent >= RANDOM_ITEMS / 3) begin
            sender_idle_pct    = 86;
            receiver_stall_pct = 14;
         end
         if ($urandom_range(99) < 70)
            send_timer_sequence();
         else
            repeat ($urandom_range(1, 4)) send_noise();
      end

      // Underflow while already in fast mode: the count wraps again, the flag stays.
      send_request(itp_pkg::OP_WRITE, itp_pkg::SEL_8, 8'h00);
      send_ticks(7 + 256 + 2);
      send_request(itp_pkg::OP_READ_STATUS, itp_pkg::SEL_8, 8'h00);
      send_request(itp_pkg::OP_READ_COUNT, itp_pkg::SEL_8, 8'h00);
      send_ticks(9);
      send_request(itp_pkg::OP_READ_COUNT, itp_pkg::SEL_8, 8'h00);

      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
